// File: design/pid_valve_drive_core_defines.svh
// assertion macros shared by the valve drive rtl
`ifndef PID_VALVE_DRIVE_CORE_DEFINES_SVH
`define PID_VALVE_DRIVE_CORE_DEFINES_SVH

`ifndef SYNTH

// same-cycle implication, sampled on clock, off during reset
`define PVD_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("%m: check failed");

// next-cycle implication, sampled on clock, off during reset
`define PVD_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("%m: check failed");

`else

`define PVD_ASSERT_IMPL(lbl, ante, cons)
`define PVD_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// File: design/pvd_pkg.sv
// types and constants of the valve drive pid block
`timescale 1ns / 1ps

package pvd_pkg;

   // item field widths
   localparam int POS_WIDTH   = 16;
   localparam int ERR_WIDTH   = POS_WIDTH + 1;
   localparam int DIFF_WIDTH  = POS_WIDTH + 2;
   localparam int EL_WIDTH    = 16;
   localparam int GAIN_WIDTH  = 16;
   localparam int CTRL_WIDTH  = 17;
   localparam int DRIVE_WIDTH = 16;
   localparam int FRAC_BITS   = 8;

   // integral accumulator
   localparam int INTEG_WIDTH = 48;
   localparam logic [INTEG_WIDTH-1:0] INTEG_MAX = {1'b0, {(INTEG_WIDTH-1){1'b1}}};
   localparam logic [INTEG_WIDTH-1:0] INTEG_MIN = {1'b1, {(INTEG_WIDTH-1){1'b0}}};

   // shared multiplier
   localparam int MUL_WIDTH  = 32;
   localparam int PROD_WIDTH = 2 * MUL_WIDTH;

   // microseconds per second
   localparam int US_WIDTH = 20;
   localparam logic [US_WIDTH-1:0] US_PER_S = 20'd1000000;
   localparam logic [PROD_WIDTH-1:0] US_PER_S_HI =
      {{(PROD_WIDTH-MUL_WIDTH-US_WIDTH){1'b0}}, US_PER_S, {MUL_WIDTH{1'b0}}};

   // iterative divider
   localparam int DVD_WIDTH     = 64;
   localparam int DVS_WIDTH     = US_WIDTH;
   localparam int QUO_WIDTH     = 56;
   localparam int DIV_STEPS     = 4;
   localparam int DIV_I_BITS    = 44;
   localparam int DIV_D_BITS    = QUO_WIDTH;
   localparam int DIV_CNT_WIDTH = 4;
   localparam logic [DIV_CNT_WIDTH-1:0] DIV_I_CYCLES =
      DIV_CNT_WIDTH'(DIV_I_BITS / DIV_STEPS);
   localparam logic [DIV_CNT_WIDTH-1:0] DIV_D_CYCLES =
      DIV_CNT_WIDTH'(DIV_D_BITS / DIV_STEPS);

   // signed sum of the three terms
   localparam int SUM_WIDTH = QUO_WIDTH + 2;
   localparam logic [DRIVE_WIDTH-1:0] DRIVE_MAX = {DRIVE_WIDTH{1'b1}};

   // register file
   localparam int CSR_ADDR_WIDTH = 5;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int REG_IDX_WIDTH  = 3;
   localparam int REG_ADDR_LSB   = 2;
   localparam logic [REG_IDX_WIDTH-1:0] REG_GAIN_PROP        = 3'd0;
   localparam logic [REG_IDX_WIDTH-1:0] REG_GAIN_INTEG       = 3'd1;
   localparam logic [REG_IDX_WIDTH-1:0] REG_GAIN_DERIV       = 3'd2;
   localparam logic [REG_IDX_WIDTH-1:0] REG_DEADBAND_EXTEND  = 3'd3;
   localparam logic [REG_IDX_WIDTH-1:0] REG_DEADBAND_RETRACT = 3'd4;
   localparam logic [GAIN_WIDTH-1:0] GAIN_PROP_RESET = 16'd200;

   // divider control and status
   typedef struct packed {
      logic start;
      logic long_div;
   } pvd_div_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } pvd_div_stat_type;

endpackage

// File: design/pvd_req_if.sv
// sample item channel
`timescale 1ns / 1ps

interface pvd_req_if;
   import pvd_pkg::*;

   logic                        valid;
   logic                        ready;
   logic signed [POS_WIDTH-1:0] setpoint;
   logic signed [POS_WIDTH-1:0] measured;
   logic [EL_WIDTH-1:0]         elapsed_us;
   logic                        clear_integral;

   modport source (output valid, setpoint, measured, elapsed_us, clear_integral,
                   input ready);
   modport sink   (input valid, setpoint, measured, elapsed_us, clear_integral,
                   output ready);
endinterface

// File: design/pvd_rsp_if.sv
// result item channel
`timescale 1ns / 1ps

interface pvd_rsp_if;
   import pvd_pkg::*;

   logic                         valid;
   logic                         ready;
   logic signed [CTRL_WIDTH-1:0] control_value;
   logic [DRIVE_WIDTH-1:0]       drive_extend;
   logic [DRIVE_WIDTH-1:0]       drive_retract;

   modport source (output valid, control_value, drive_extend, drive_retract,
                   input ready);
   modport sink   (input valid, control_value, drive_extend, drive_retract,
                   output ready);
endinterface

// File: design/pid_valve_drive_core.sv
// positional pid controller with split extend and retract valve drives
`timescale 1ns / 1ps
`include "pid_valve_drive_core_defines.svh"

// Each sample item (setpoint, measured, elapsed_us, clear_integral) yields one
// result item. The error setpoint - measured is integrated as error times
// elapsed microseconds into a 48-bit saturating accumulator; the integral
// term is gain_integ * integral / 1e6, the derivative term is
// gain_deriv * (error - previous error) * 1e6 / elapsed_us (zero when elapsed
// is zero), the proportional term gain_prop * error; all three are exact and
// truncate toward zero. control_value is the integer part of the Q49.8 sum,
// saturated to +-65535. A positive sum sends its magnitude plus the extend
// dead band to the extend drive, a zero or negative sum sends it plus the
// retract dead band to the retract drive; both saturate at 65535. The
// result item is loaded into the output register in ST_OUT, which waits
// while an earlier result has not been taken, and the next item can be
// accepted in the cycle the result appears. All products go through one
// 32x32 multiplier in turn, and both divisions through one divider that
// retires four quotient bits per cycle; the derivative division is skipped
// when elapsed_us is zero. req_chan.ready is high only while no item is in
// work; a finished result sits in an output register so the next item can
// be taken while it waits. Registers sit at byte addresses 0, 4, 8, 12,
// 16; write them only while the block is idle, the block does not enforce it.

module pid_valve_drive_core (
   input  logic                                clock,
   input  logic                                reset,
   pvd_req_if.sink                             req_chan,
   pvd_rsp_if.source                           rsp_chan,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [pvd_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [pvd_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic [pvd_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                                csr_pready
);
   import pvd_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_DELTA,   // error * elapsed
      ST_MUL_P,       // gain_prop * error, integral update
      ST_MUL_I_HI,    // gain_integ * upper integral bits
      ST_MUL_I_LO,    // gain_integ * lower integral bits
      ST_MUL_D,       // gain_deriv * error difference
      ST_MUL_D_US,    // times 1e6, integral divide starts
      ST_D_DIVIDEND,  // finish derivative dividend
      ST_WAIT_I,      // integral quotient, derivative divide starts unless elapsed is zero
      ST_WAIT_D,      // derivative quotient
      ST_SUM_PI,
      ST_SUM_D,
      ST_MAG,
      ST_OUT
   } state_type;

   // ------------------------------------------------------------------
   // configuration registers
   // ------------------------------------------------------------------
   logic [GAIN_WIDTH-1:0]    gain_prop_ff, gain_integ_ff, gain_deriv_ff;
   logic [DRIVE_WIDTH-1:0]   db_extend_ff, db_retract_ff;
   logic                     csr_wr;
   logic [REG_IDX_WIDTH-1:0] csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_idx    = csr_paddr[REG_ADDR_LSB +: REG_IDX_WIDTH];

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_prop_ff  <= GAIN_PROP_RESET;
         gain_integ_ff <= '0;
         gain_deriv_ff <= '0;
         db_extend_ff  <= '0;
         db_retract_ff <= '0;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_GAIN_PROP:        gain_prop_ff  <= csr_pwdata[GAIN_WIDTH-1:0];
            REG_GAIN_INTEG:       gain_integ_ff <= csr_pwdata[GAIN_WIDTH-1:0];
            REG_GAIN_DERIV:       gain_deriv_ff <= csr_pwdata[GAIN_WIDTH-1:0];
            REG_DEADBAND_EXTEND:  db_extend_ff  <= csr_pwdata[DRIVE_WIDTH-1:0];
            REG_DEADBAND_RETRACT: db_retract_ff <= csr_pwdata[DRIVE_WIDTH-1:0];
            default: begin
               // addresses past the register list are ignored
            end
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_GAIN_PROP:        csr_prdata = CSR_DATA_WIDTH'(gain_prop_ff);
         REG_GAIN_INTEG:       csr_prdata = CSR_DATA_WIDTH'(gain_integ_ff);
         REG_GAIN_DERIV:       csr_prdata = CSR_DATA_WIDTH'(gain_deriv_ff);
         REG_DEADBAND_EXTEND:  csr_prdata = CSR_DATA_WIDTH'(db_extend_ff);
         REG_DEADBAND_RETRACT: csr_prdata = CSR_DATA_WIDTH'(db_retract_ff);
         default:              csr_prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------
   // datapath registers
   // ------------------------------------------------------------------
   state_type              state_ff, state_in;
   logic [ERR_WIDTH-1:0]   err_ff, err_in;
   logic [ERR_WIDTH-1:0]   prev_ff, prev_in;
   logic [DIFF_WIDTH-1:0]  diff_ff, diff_in;
   logic [EL_WIDTH-1:0]    el_ff, el_in;
   logic                   clr_ff, clr_in;
   logic [INTEG_WIDTH-1:0] acc_ff, acc_in;
   logic [MUL_WIDTH-1:0]   p_ff, p_in;
   logic [DIV_I_BITS-1:0]  i_ff, i_in;
   logic [QUO_WIDTH-1:0]   d_ff, d_in;
   logic [PROD_WIDTH-1:0]  wide_ff, wide_in;
   logic [PROD_WIDTH-1:0]  dd_ff, dd_in;
   logic                   xhi_ff, xhi_in;
   logic [SUM_WIDTH-1:0]   sum_ff, sum_in;
   logic [SUM_WIDTH-1:0]   mag_ff, mag_in;
   logic                   neg_ff, neg_in;
   logic                   pos_ff, pos_in;

   // result register
   logic                   out_valid_ff, out_valid_in;
   logic [CTRL_WIDTH-1:0]  out_ctrl_ff, out_ctrl_in;
   logic [DRIVE_WIDTH-1:0] out_ext_ff, out_ext_in;
   logic [DRIVE_WIDTH-1:0] out_ret_ff, out_ret_in;
   logic                   out_load;

   // shared units
   logic [MUL_WIDTH-1:0]   mul_a, mul_b;
   logic [PROD_WIDTH-1:0]  prod;
   pvd_div_cmd_type        div_cmd;
   pvd_div_stat_type       div_stat;
   logic [DVD_WIDTH-1:0]   div_dividend;
   logic [DVS_WIDTH-1:0]   div_divisor;
   logic [QUO_WIDTH-1:0]   quotient;

   pvd_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .prod  (prod)
   );

   pvd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .div_cmd  (div_cmd),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .div_stat (div_stat),
      .quotient (quotient)
   );

   // ------------------------------------------------------------------
   // magnitudes and signed terms
   // ------------------------------------------------------------------
   logic                    err_neg, diff_neg, acc_neg;
   logic [ERR_WIDTH-1:0]    err_abs;
   logic [DIFF_WIDTH-1:0]   diff_abs;
   logic [INTEG_WIDTH-1:0]  acc_abs;
   logic [INTEG_WIDTH:0]    delta_s, acc_sum;
   logic [SUM_WIDTH-1:0]    p_ext, i_ext, d_ext, p_term, i_term, d_term;
   logic [DRIVE_WIDTH-1:0]  ctrl_mag;
   logic [DRIVE_WIDTH:0]    ext_sum, ret_sum;
   logic [DRIVE_WIDTH-1:0]  ext_sat, ret_sat;

   assign err_neg  = err_ff[ERR_WIDTH-1];
   assign diff_neg = diff_ff[DIFF_WIDTH-1];
   assign acc_neg  = acc_ff[INTEG_WIDTH-1];
   assign err_abs  = err_neg ? (~err_ff + 1'b1) : err_ff;
   assign diff_abs = diff_neg ? (~diff_ff + 1'b1) : diff_ff;
   // most negative accumulator maps to 2^47, still fits unsigned
   assign acc_abs  = acc_neg ? (~acc_ff + 1'b1) : acc_ff;

   // signed error * elapsed from the product magnitude
   always_comb begin
      logic [INTEG_WIDTH:0] dmag;
      dmag    = {{(INTEG_WIDTH+1-MUL_WIDTH){1'b0}}, prod[MUL_WIDTH-1:0]};
      delta_s = err_neg ? (~dmag + 1'b1) : dmag;
      acc_sum = {acc_ff[INTEG_WIDTH-1], acc_ff} + delta_s;
   end

   assign p_ext  = {{(SUM_WIDTH-MUL_WIDTH){1'b0}}, p_ff};
   assign i_ext  = {{(SUM_WIDTH-DIV_I_BITS){1'b0}}, i_ff};
   assign d_ext  = {{(SUM_WIDTH-QUO_WIDTH){1'b0}}, d_ff};
   assign p_term = err_neg ? (~p_ext + 1'b1) : p_ext;
   assign i_term = acc_neg ? (~i_ext + 1'b1) : i_ext;
   assign d_term = diff_neg ? (~d_ext + 1'b1) : d_ext;

   // integer part of the sum, saturated, plus dead bands
   assign ctrl_mag = (|mag_ff[SUM_WIDTH-1:FRAC_BITS+DRIVE_WIDTH]) ? DRIVE_MAX
                     : mag_ff[FRAC_BITS +: DRIVE_WIDTH];
   assign ext_sum  = {1'b0, ctrl_mag} + {1'b0, db_extend_ff};
   assign ret_sum  = {1'b0, ctrl_mag} + {1'b0, db_retract_ff};
   assign ext_sat  = ext_sum[DRIVE_WIDTH] ? DRIVE_MAX : ext_sum[DRIVE_WIDTH-1:0];
   assign ret_sat  = ret_sum[DRIVE_WIDTH] ? DRIVE_MAX : ret_sum[DRIVE_WIDTH-1:0];

   assign out_load = (state_ff == ST_OUT) && (!out_valid_ff || rsp_chan.ready);

   // ------------------------------------------------------------------
   // sequencer
   // ------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      err_in       = err_ff;
      prev_in      = prev_ff;
      diff_in      = diff_ff;
      el_in        = el_ff;
      clr_in       = clr_ff;
      acc_in       = acc_ff;
      p_in         = p_ff;
      i_in         = i_ff;
      d_in         = d_ff;
      wide_in      = wide_ff;
      dd_in        = dd_ff;
      xhi_in       = xhi_ff;
      sum_in       = sum_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      pos_in       = pos_ff;
      out_ctrl_in  = out_ctrl_ff;
      out_ext_in   = out_ext_ff;
      out_ret_in   = out_ret_ff;
      mul_a        = '0;
      mul_b        = '0;
      div_cmd      = '0;
      div_dividend = wide_ff;
      div_divisor  = US_PER_S;

      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               err_in   = {req_chan.setpoint[POS_WIDTH-1], req_chan.setpoint}
                        - {req_chan.measured[POS_WIDTH-1], req_chan.measured};
               el_in    = req_chan.elapsed_us;
               clr_in   = req_chan.clear_integral;
               state_in = ST_MUL_DELTA;
            end
         end
         ST_MUL_DELTA: begin
            mul_a    = {{(MUL_WIDTH-POS_WIDTH){1'b0}}, err_abs[POS_WIDTH-1:0]};
            mul_b    = {{(MUL_WIDTH-EL_WIDTH){1'b0}}, el_ff};
            diff_in  = {err_ff[ERR_WIDTH-1], err_ff} - {prev_ff[ERR_WIDTH-1], prev_ff};
            prev_in  = err_ff;
            if (clr_ff) begin
               acc_in = '0;
            end
            state_in = ST_MUL_P;
         end
         ST_MUL_P: begin
            mul_a = {{(MUL_WIDTH-POS_WIDTH){1'b0}}, err_abs[POS_WIDTH-1:0]};
            mul_b = {{(MUL_WIDTH-GAIN_WIDTH){1'b0}}, gain_prop_ff};
            // saturating integral update
            if (acc_sum[INTEG_WIDTH] != acc_sum[INTEG_WIDTH-1]) begin
               acc_in = acc_sum[INTEG_WIDTH] ? INTEG_MIN : INTEG_MAX;
            end else begin
               acc_in = acc_sum[INTEG_WIDTH-1:0];
            end
            state_in = ST_MUL_I_HI;
         end
         ST_MUL_I_HI: begin
            mul_a    = {{(2*MUL_WIDTH-INTEG_WIDTH){1'b0}}, acc_abs[INTEG_WIDTH-1:MUL_WIDTH]};
            mul_b    = {{(MUL_WIDTH-GAIN_WIDTH){1'b0}}, gain_integ_ff};
            p_in     = prod[MUL_WIDTH-1:0];
            state_in = ST_MUL_I_LO;
         end
         ST_MUL_I_LO: begin
            mul_a    = acc_abs[MUL_WIDTH-1:0];
            mul_b    = {{(MUL_WIDTH-GAIN_WIDTH){1'b0}}, gain_integ_ff};
            wide_in  = {prod[MUL_WIDTH-1:0], {MUL_WIDTH{1'b0}}};
            state_in = ST_MUL_D;
         end
         ST_MUL_D: begin
            mul_a    = {{(MUL_WIDTH-DIFF_WIDTH+1){1'b0}}, diff_abs[DIFF_WIDTH-2:0]};
            mul_b    = {{(MUL_WIDTH-GAIN_WIDTH){1'b0}}, gain_deriv_ff};
            wide_in  = wide_ff + prod;
            state_in = ST_MUL_D_US;
         end
         ST_MUL_D_US: begin
            // gain_deriv * |diff| spills one bit past the multiplier width
            mul_a            = prod[MUL_WIDTH-1:0];
            mul_b            = {{(MUL_WIDTH-US_WIDTH){1'b0}}, US_PER_S};
            xhi_in           = prod[MUL_WIDTH];
            div_cmd.start    = 1'b1;
            div_cmd.long_div = 1'b0;
            div_dividend     = wide_ff;
            div_divisor      = US_PER_S;
            state_in         = ST_D_DIVIDEND;
         end
         ST_D_DIVIDEND: begin
            dd_in    = prod + (xhi_ff ? US_PER_S_HI : '0);
            state_in = ST_WAIT_I;
         end
         ST_WAIT_I: begin
            div_dividend = dd_ff;
            div_divisor  = {{(DVS_WIDTH-EL_WIDTH){1'b0}}, el_ff};
            if (div_stat.done) begin
               i_in = quotient[DIV_I_BITS-1:0];
               if (el_ff != '0) begin
                  div_cmd.start    = 1'b1;
                  div_cmd.long_div = 1'b1;
                  state_in         = ST_WAIT_D;
               end else begin
                  // zero elapsed time: no derivative
                  d_in     = '0;
                  state_in = ST_SUM_PI;
               end
            end
         end
         ST_WAIT_D: begin
            if (div_stat.done) begin
               d_in     = quotient;
               state_in = ST_SUM_PI;
            end
         end
         ST_SUM_PI: begin
            sum_in   = p_term + i_term;
            state_in = ST_SUM_D;
         end
         ST_SUM_D: begin
            sum_in   = sum_ff + d_term;
            state_in = ST_MAG;
         end
         ST_MAG: begin
            neg_in   = sum_ff[SUM_WIDTH-1];
            pos_in   = !sum_ff[SUM_WIDTH-1] && (sum_ff != '0);
            mag_in   = sum_ff[SUM_WIDTH-1] ? (~sum_ff + 1'b1) : sum_ff;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_load) begin
               out_ctrl_in = neg_ff ? (~{1'b0, ctrl_mag} + 1'b1) : {1'b0, ctrl_mag};
               out_ext_in  = pos_ff ? ext_sat : '0;
               out_ret_in  = pos_ff ? '0 : ret_sat;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign out_valid_in = out_load | (out_valid_ff & ~rsp_chan.ready);

   always_ff @(posedge clock) begin
      err_ff      <= err_in;
      diff_ff     <= diff_in;
      el_ff       <= el_in;
      clr_ff      <= clr_in;
      p_ff        <= p_in;
      i_ff        <= i_in;
      d_ff        <= d_in;
      wide_ff     <= wide_in;
      dd_ff       <= dd_in;
      xhi_ff      <= xhi_in;
      sum_ff      <= sum_in;
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      pos_ff      <= pos_in;
      out_ctrl_ff <= out_ctrl_in;
      out_ext_ff  <= out_ext_in;
      out_ret_ff  <= out_ret_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         acc_ff       <= '0;
         prev_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         acc_ff       <= acc_in;
         prev_ff      <= prev_in;
      end
   end

   assign req_chan.ready         = (state_ff == ST_IDLE);
   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.control_value = out_ctrl_ff;
   assign rsp_chan.drive_extend  = out_ext_ff;
   assign rsp_chan.drive_retract = out_ret_ff;

   `PVD_ASSERT_NEXT(a_busy_after_accept, req_chan.valid && req_chan.ready, !req_chan.ready)
   `PVD_ASSERT_IMPL(a_one_drive_active, rsp_chan.valid,
                    rsp_chan.drive_extend == '0 || rsp_chan.drive_retract == '0)
   `PVD_ASSERT_IMPL(a_ctrl_in_range, rsp_chan.valid,
                    (rsp_chan.control_value != {1'b1, {(CTRL_WIDTH-1){1'b0}}}))
   `PVD_ASSERT_IMPL(a_div_start_idle, div_cmd.start, !div_stat.busy)
endmodule

// File: design/pvd_mul.sv
// shared unsigned multiplier with registered product
`timescale 1ns / 1ps

module pvd_mul (
   input  logic                             clock,
   input  logic [pvd_pkg::MUL_WIDTH-1:0]    mul_a,
   input  logic [pvd_pkg::MUL_WIDTH-1:0]    mul_b,
   output logic [pvd_pkg::PROD_WIDTH-1:0]   prod
);
   import pvd_pkg::*;

   logic [PROD_WIDTH-1:0] prod_ff;
   logic [PROD_WIDTH-1:0] prod_in;

   assign prod_in = PROD_WIDTH'(mul_a) * PROD_WIDTH'(mul_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;
endmodule

// File: design/pvd_div.sv
// restoring divider, four quotient bits per cycle
`timescale 1ns / 1ps
`include "pid_valve_drive_core_defines.svh"

module pvd_div (
   input  logic                             clock,
   input  logic                             reset,
   input  pvd_pkg::pvd_div_cmd_type         div_cmd,
   input  logic [pvd_pkg::DVD_WIDTH-1:0]    dividend,
   input  logic [pvd_pkg::DVS_WIDTH-1:0]    divisor,
   output pvd_pkg::pvd_div_stat_type        div_stat,
   output logic [pvd_pkg::QUO_WIDTH-1:0]    quotient
);
   import pvd_pkg::*;

   localparam int LONG_TOP  = DVD_WIDTH - DIV_D_BITS;
   localparam int SHORT_TOP = DVD_WIDTH - DIV_I_BITS;

   logic [DVS_WIDTH-1:0]     rem_ff, rem_in;
   logic [DVD_WIDTH-1:0]     dvd_ff, dvd_in;
   logic [DVS_WIDTH-1:0]     dvs_ff, dvs_in;
   logic [DIV_CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [DVS_WIDTH-1:0]     step_rem;
   logic [DVD_WIDTH-1:0]     step_dvd;

   // four dependent compare-subtract steps on the narrow remainder
   always_comb begin
      logic [DVS_WIDTH-1:0] r;
      logic [DVD_WIDTH-1:0] d;
      logic [DVS_WIDTH:0]   t;
      r = rem_ff;
      d = dvd_ff;
      t = '0;
      for (int k = 0; k < DIV_STEPS; k++) begin
         t = {r, d[DVD_WIDTH-1]};
         d = {d[DVD_WIDTH-2:0], 1'b0};
         if (t >= {1'b0, dvs_ff}) begin
            r    = t[DVS_WIDTH-1:0] - dvs_ff;
            d[0] = 1'b1;
         end else begin
            r = t[DVS_WIDTH-1:0];
         end
      end
      step_rem = r;
      step_dvd = d;
   end

   always_comb begin
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_cmd.start) begin
         dvs_in  = divisor;
         busy_in = 1'b1;
         if (div_cmd.long_div) begin
            rem_in = {{(DVS_WIDTH-LONG_TOP){1'b0}}, dividend[DVD_WIDTH-1 -: LONG_TOP]};
            dvd_in = {dividend[DIV_D_BITS-1:0], {LONG_TOP{1'b0}}};
            cnt_in = DIV_D_CYCLES;
         end else begin
            rem_in = dividend[DVD_WIDTH-1 -: SHORT_TOP];
            dvd_in = {dividend[DIV_I_BITS-1:0], {SHORT_TOP{1'b0}}};
            cnt_in = DIV_I_CYCLES;
         end
      end else if (busy_ff) begin
         rem_in = step_rem;
         dvd_in = step_dvd;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_WIDTH'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign div_stat.busy = busy_ff;
   assign div_stat.done = done_ff;
   assign quotient      = dvd_ff[QUO_WIDTH-1:0];

   `PVD_ASSERT_NEXT(a_start_sets_busy, div_cmd.start, div_stat.busy)
   `PVD_ASSERT_IMPL(a_done_after_busy, div_stat.done, $past(div_stat.busy))
   `PVD_ASSERT_IMPL(a_done_not_busy, div_stat.done, !div_stat.busy)
endmodule
